### sv/rknl_pkg.sv
// ----------------------------------------------------------------------------
// rknl_pkg
// Shared types and constants of the relational, keyword and number lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rknl_pkg;

  localparam int MAX_LINE_LENGTH = 4096;
  localparam int COL_W           = 12;
  localparam int COL_LIMIT       = (MAX_LINE_LENGTH - 1 < (1 << COL_W) - 1) ?
                                   MAX_LINE_LENGTH - 1 : (1 << COL_W) - 1;
  localparam logic [COL_W-1:0] COL_MAX = COL_LIMIT[COL_W-1:0];

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] TOK_IF      = 3'd0;
  localparam logic [2:0] TOK_ELSE    = 3'd1;
  localparam logic [2:0] TOK_THEN    = 3'd2;
  localparam logic [2:0] TOK_IDENT   = 3'd3;
  localparam logic [2:0] TOK_NUMBER  = 3'd4;
  localparam logic [2:0] TOK_RELOP   = 3'd5;
  localparam logic [2:0] TOK_UNKNOWN = 3'd6;

  localparam logic [2:0] REL_EQ = 3'd0;
  localparam logic [2:0] REL_LT = 3'd1;
  localparam logic [2:0] REL_LE = 3'd2;
  localparam logic [2:0] REL_NE = 3'd3;
  localparam logic [2:0] REL_GT = 3'd4;
  localparam logic [2:0] REL_GE = 3'd5;

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       relop;
    logic [COL_W-1:0] start;
    logic [COL_W-1:0] length;
    logic             last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } emit_t;

endpackage

`default_nettype wire

### sv/rknl_scan.sv
// ----------------------------------------------------------------------------
// rknl_scan
// Run state of the lexer: classifies each character, advances the keyword,
// number and operator automata, and forms the tokens a character closes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rknl_scan (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    ch_i,
  input  wire logic          line_end_i,
  output rknl_pkg::emit_t    emit_o
);
  import rknl_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ID   = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_REL  = 2'd3
  } mode_e;

  localparam logic [3:0] KW_NONE = 4'd0;
  localparam logic [3:0] KW_I    = 4'd1;
  localparam logic [3:0] KW_IF   = 4'd2;
  localparam logic [3:0] KW_E    = 4'd3;
  localparam logic [3:0] KW_EL   = 4'd4;
  localparam logic [3:0] KW_ELS  = 4'd5;
  localparam logic [3:0] KW_ELSE = 4'd6;
  localparam logic [3:0] KW_T    = 4'd7;
  localparam logic [3:0] KW_TH   = 4'd8;
  localparam logic [3:0] KW_THE  = 4'd9;
  localparam logic [3:0] KW_THEN = 4'd10;

  localparam logic [2:0] NUM_START = 3'd0;
  localparam logic [2:0] NUM_INT   = 3'd1;
  localparam logic [2:0] NUM_DOT   = 3'd2;
  localparam logic [2:0] NUM_FRAC  = 3'd3;
  localparam logic [2:0] NUM_EMARK = 3'd4;
  localparam logic [2:0] NUM_SIGN  = 3'd5;
  localparam logic [2:0] NUM_EXP   = 3'd6;
  localparam logic [2:0] NUM_DEAD  = 3'd7;

  function automatic logic [3:0] kw_next(logic [3:0] p, logic [7:0] c);
    logic [3:0] r;
    r = KW_NONE;
    case (p)
      KW_I:   r = (c == "f") ? KW_IF   : KW_NONE;
      KW_E:   r = (c == "l") ? KW_EL   : KW_NONE;
      KW_EL:  r = (c == "s") ? KW_ELS  : KW_NONE;
      KW_ELS: r = (c == "e") ? KW_ELSE : KW_NONE;
      KW_T:   r = (c == "h") ? KW_TH   : KW_NONE;
      KW_TH:  r = (c == "e") ? KW_THE  : KW_NONE;
      KW_THE: r = (c == "n") ? KW_THEN : KW_NONE;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] num_next(logic [2:0] s, logic [7:0] c);
    logic       d;
    logic       e;
    logic [2:0] r;
    d = (c >= "0") && (c <= "9");
    e = (c == "e") || (c == "E");
    r = NUM_DEAD;
    case (s)
      NUM_START: r = d ? NUM_INT : NUM_DEAD;
      NUM_INT:   r = d ? NUM_INT : ((c == ".") ? NUM_DOT : (e ? NUM_EMARK : NUM_DEAD));
      NUM_DOT:   r = d ? NUM_FRAC : NUM_DEAD;
      NUM_FRAC:  r = d ? NUM_FRAC : (e ? NUM_EMARK : NUM_DEAD);
      NUM_EMARK: r = d ? NUM_EXP : (((c == "+") || (c == "-")) ? NUM_SIGN : NUM_DEAD);
      NUM_SIGN:  r = d ? NUM_EXP : NUM_DEAD;
      NUM_EXP:   r = d ? NUM_EXP : NUM_DEAD;
      default:   r = NUM_DEAD;
    endcase
    return r;
  endfunction

  function automatic token_t make_token(mode_e m, logic [3:0] kw, logic [2:0] num,
                                        logic [2:0] rel, logic [COL_W-1:0] start,
                                        logic [COL_W-1:0] len);
    token_t t;
    t        = '0;
    t.start  = start;
    t.length = len;
    case (m)
      MODE_ID: begin
        if (kw == KW_IF)        t.kind = TOK_IF;
        else if (kw == KW_ELSE) t.kind = TOK_ELSE;
        else if (kw == KW_THEN) t.kind = TOK_THEN;
        else                    t.kind = TOK_IDENT;
      end
      MODE_NUM: begin
        t.kind = ((num == NUM_INT) || (num == NUM_FRAC) || (num == NUM_EXP)) ?
                 TOK_NUMBER : TOK_UNKNOWN;
      end
      default: begin
        t.kind  = TOK_RELOP;
        t.relop = rel;
      end
    endcase
    return t;
  endfunction

  mode_e            mode_q, mode_d, mode_mid;
  logic [3:0]       kw_q, kw_d;
  logic [2:0]       num_q, num_d;
  logic [2:0]       rel_q, rel_d;
  logic [COL_W-1:0] start_q, start_d;
  logic [COL_W-1:0] len_q, len_d;
  logic [COL_W-1:0] col_q, col_d;

  logic   is_letter, is_digit, is_rel, is_ident, is_numc, cont;
  logic   emit_a, emit_b;
  token_t tok_a, tok_b;

  always_comb begin
    is_letter = ((ch_i >= "a") && (ch_i <= "z")) || ((ch_i >= "A") && (ch_i <= "Z"));
    is_digit  = (ch_i >= "0") && (ch_i <= "9");
    is_rel    = (ch_i == "<") || (ch_i == ">") || (ch_i == "=");
    is_ident  = is_letter || is_digit || (ch_i == "_");
    is_numc   = is_digit || (ch_i == ".") || (ch_i == "e") || (ch_i == "E") ||
                (ch_i == "+") || (ch_i == "-");
    case (mode_q)
      MODE_ID:  cont = is_ident;
      MODE_NUM: cont = is_numc;
      MODE_REL: cont = is_rel;
      default:  cont = 1'b0;
    endcase

    mode_mid = mode_q;
    kw_d     = kw_q;
    num_d    = num_q;
    rel_d    = rel_q;
    start_d  = start_q;
    len_d    = len_q;
    emit_a   = 1'b0;
    tok_a    = make_token(mode_q, kw_q, num_q, rel_q, start_q, len_q);

    if (cont) begin
      case (mode_q)
        MODE_ID:  kw_d  = kw_next(kw_q, ch_i);
        MODE_NUM: num_d = num_next(num_q, ch_i);
        default: begin
          if (len_q == COL_W'(1)) begin
            if ((rel_q == REL_LT) && (ch_i == "="))      rel_d = REL_LE;
            else if ((rel_q == REL_LT) && (ch_i == ">")) rel_d = REL_NE;
            else if ((rel_q == REL_GT) && (ch_i == "=")) rel_d = REL_GE;
          end
        end
      endcase
      if (len_q != '1) len_d = len_q + COL_W'(1);
    end else begin
      emit_a   = (mode_q != MODE_IDLE);
      mode_mid = MODE_IDLE;
      if (is_letter || (ch_i == "_")) begin
        mode_mid = MODE_ID;
        kw_d     = (ch_i == "i") ? KW_I : ((ch_i == "e") ? KW_E :
                   ((ch_i == "t") ? KW_T : KW_NONE));
      end else if (is_digit) begin
        mode_mid = MODE_NUM;
        num_d    = num_next(NUM_START, ch_i);
      end else if (is_rel) begin
        mode_mid = MODE_REL;
        rel_d    = (ch_i == "=") ? REL_EQ : ((ch_i == "<") ? REL_LT : REL_GT);
      end
      if (mode_mid != MODE_IDLE) begin
        start_d = col_q;
        len_d   = COL_W'(1);
      end
    end

    tok_b  = make_token(mode_mid, kw_d, num_d, rel_d, start_d, len_d);
    emit_b = line_end_i && (mode_mid != MODE_IDLE);
    mode_d = line_end_i ? MODE_IDLE : mode_mid;

    if (line_end_i)          col_d = '0;
    else if (col_q < COL_MAX) col_d = col_q + COL_W'(1);
    else                     col_d = col_q;

    tok_a.last  = !emit_b;
    tok_b.last  = 1'b1;
    emit_o.tok0 = emit_a ? tok_a : tok_b;
    emit_o.tok1 = tok_b;
    emit_o.count = step_i ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      kw_q    <= KW_NONE;
      num_q   <= NUM_START;
      rel_q   <= REL_EQ;
      start_q <= '0;
      len_q   <= '0;
      col_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      num_q   <= num_d;
      rel_q   <= rel_d;
      start_q <= start_d;
      len_q   <= len_d;
      col_q   <= col_d;
    end
  end

endmodule

`default_nettype wire

### sv/relop_keyword_number_lexer.sv
// ----------------------------------------------------------------------------
// relop_keyword_number_lexer
// Character-stream lexer for the keywords if, else and then, identifiers,
// numbers and relational operators, with column and length per token.
// ----------------------------------------------------------------------------
// Takes one character per clock. The run state advances in the cycle the
// character transfers, and the tokens it closes land in a four-entry output
// queue, so a token is registered before it is offered. A character that
// closes a run and also a one-character run at line end gives two tokens,
// which leave the queue one after the other. Input ready is low while the
// queue holds more than two tokens. With the output side always ready, the
// queue never holds more than two tokens, so the block takes one character
// every clock; only output stalls hold the input back.
`timescale 1ns / 1ps
`default_nettype none

module relop_keyword_number_lexer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [7:0]                ch_i,
  input  wire logic                      line_end_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [2:0]                token_kind_o,
  output      logic [2:0]                relop_kind_o,
  output      logic [rknl_pkg::COL_W-1:0] start_column_o,
  output      logic [rknl_pkg::COL_W-1:0] token_length_o,
  output      logic                      last_of_item_o
);
  import rknl_pkg::*;

  token_t           fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             step, pop;
  emit_t            emit;
  token_t           head;

  assign in_ready_o = (count_q <= CNT_W'(FIFO_DEPTH - 2));
  assign step       = in_valid_i && in_ready_o;

  rknl_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ch_i       (ch_i),
    .line_end_i (line_end_i),
    .emit_o     (emit)
  );

  assign head           = fifo_q[rd_ptr_q];
  assign out_valid_o    = (count_q != '0);
  assign pop            = out_valid_o && out_ready_i;
  assign token_kind_o   = head.kind;
  assign relop_kind_o   = head.relop;
  assign start_column_o = head.start;
  assign token_length_o = head.length;
  assign last_of_item_o = head.last;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(emit.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(emit.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.count != 2'd0) begin
      fifo_q[wr_ptr_q] <= emit.tok0;
    end
    if (emit.count == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= emit.tok1;
    end
  end

endmodule

`default_nettype wire

### sv/rknl_checker.sv
// ----------------------------------------------------------------------------
// rknl_checker
// Port-level checks of the lexer's channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rknl_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic [7:0]                 ch_i,
  input wire logic                       line_end_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [2:0]                 token_kind_o,
  input wire logic [2:0]                 relop_kind_o,
  input wire logic [rknl_pkg::COL_W-1:0] start_column_o,
  input wire logic [rknl_pkg::COL_W-1:0] token_length_o,
  input wire logic                       last_of_item_o
);
  import rknl_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(ch_i) && $stable(line_end_i))
    else $error("input transfer dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(relop_kind_o) && $stable(start_column_o) && $stable(token_length_o) &&
    $stable(last_of_item_o))
    else $error("output token changed while stalled");

  a_relop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != TOK_RELOP) |-> relop_kind_o == REL_EQ)
    else $error("operator code on a non-operator token");

  a_len_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (token_length_o != '0) && (token_kind_o <= TOK_UNKNOWN))
    else $error("empty token or bad token kind");

  a_keyword_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == TOK_IF || token_kind_o == TOK_ELSE ||
    token_kind_o == TOK_THEN) |->
    token_length_o == ((token_kind_o == TOK_IF) ? COL_W'(2) : COL_W'(4)))
    else $error("keyword token with wrong length");

endmodule

bind relop_keyword_number_lexer rknl_checker u_rknl_checker (.*);

`default_nettype wire

### dv/relop_keyword_number_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relop_keyword_number_lexer_tb
// Self-checking bench for the character-stream lexer. A short directed set of
// lines hits the keywords, every operator, numbers good and bad, the skipped
// byte extremes and a two-token line end. Random lines of tokens, noise lines
// and one long line follow. A scoreboard predicts every token and checks
// it field by field, with random idle and stall on both handshakes.
// ----------------------------------------------------------------------------

module relop_keyword_number_lexer_tb;
  import rknl_pkg::*;

  localparam int                IDLE_LIMIT = 2000;
  localparam int                RAND_CHARS = 1100;
  localparam int                LONG_RUN   = 300;
  localparam logic [COL_W-1:0]  LEN_MAX    = '1;

  typedef enum logic [1:0] {RUN_IDLE, RUN_IDENT, RUN_NUM, RUN_REL} run_e;
  typedef enum logic [3:0] {
    KW_NONE, KW_I, KW_IF, KW_E, KW_EL, KW_ELS, KW_ELSE, KW_T, KW_TH, KW_THE, KW_THEN
  } kw_e;
  typedef enum logic [2:0] {
    NUM_START, NUM_INT, NUM_DOT, NUM_FRAC, NUM_EXP, NUM_SIGN, NUM_EXPD, NUM_DEAD
  } num_e;

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    bit         drain;
  } char_item_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           ch_i;
  logic                 line_end_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [2:0]           token_kind_o;
  logic [2:0]           relop_kind_o;
  logic [COL_W-1:0]     start_column_o;
  logic [COL_W-1:0]     token_length_o;
  logic                 last_of_item_o;

  relop_keyword_number_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ch_i           (ch_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .relop_kind_o   (relop_kind_o),
    .start_column_o (start_column_o),
    .token_length_o (token_length_o),
    .last_of_item_o (last_of_item_o)
  );

  // lexer shadow state
  run_e             run_mode;
  kw_e              kw_state;
  num_e             num_state;
  logic [2:0]       rel_code;
  logic [COL_W-1:0] run_start;
  logic [COL_W-1:0] run_len;
  logic [COL_W-1:0] col;

  char_item_t       char_q[$];
  token_t           token_q[$];
  logic [7:0]       line_buf[$];
  string            kw_words[3] = '{"if", "else", "then"};

  char_item_t       nxt_char;
  token_t           got_tok;
  token_t           want_tok;
  int               n_offered;
  int               n_accepted;
  int               n_tokens;
  int               n_two_tok;
  int               n_lines;
  int               n_errors;
  int               idle_cycles;
  int               src_gap;
  int               src_quiet;
  int               snk_hold;
  int               snk_quiet;
  bit               long_hold_done;
  int               kind_seen[8];

  always #1 clk_i = ~clk_i;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_rel(logic [7:0] c);
    return c == "<" || c == ">" || c == "=";
  endfunction

  function automatic kw_e kw_advance(kw_e p, logic [7:0] c);
    case (p)
      KW_I:   if (c == "f") return KW_IF;
      KW_E:   if (c == "l") return KW_EL;
      KW_EL:  if (c == "s") return KW_ELS;
      KW_ELS: if (c == "e") return KW_ELSE;
      KW_T:   if (c == "h") return KW_TH;
      KW_TH:  if (c == "e") return KW_THE;
      KW_THE: if (c == "n") return KW_THEN;
      default: ;
    endcase
    return KW_NONE;
  endfunction

  function automatic num_e num_advance(num_e s, logic [7:0] c);
    bit d;
    bit e;
    d = is_digit(c);
    e = (c == "e") || (c == "E");
    case (s)
      NUM_START: if (d) return NUM_INT;
      NUM_INT: begin
        if (d) return NUM_INT;
        if (c == ".") return NUM_DOT;
        if (e) return NUM_EXP;
      end
      NUM_DOT: if (d) return NUM_FRAC;
      NUM_FRAC: begin
        if (d) return NUM_FRAC;
        if (e) return NUM_EXP;
      end
      NUM_EXP: begin
        if (d) return NUM_EXPD;
        if (c == "+" || c == "-") return NUM_SIGN;
      end
      NUM_SIGN, NUM_EXPD: if (d) return NUM_EXPD;
      default: ;
    endcase
    return NUM_DEAD;
  endfunction

  function automatic token_t close_run();
    token_t t;
    t = '0;
    case (run_mode)
      RUN_IDENT: begin
        if (kw_state == KW_IF) t.kind = TOK_IF;
        else if (kw_state == KW_ELSE) t.kind = TOK_ELSE;
        else if (kw_state == KW_THEN) t.kind = TOK_THEN;
        else t.kind = TOK_IDENT;
      end
      RUN_NUM: begin
        if (num_state inside {NUM_INT, NUM_FRAC, NUM_EXPD}) t.kind = TOK_NUMBER;
        else t.kind = TOK_UNKNOWN;
      end
      default: begin
        t.kind  = TOK_RELOP;
        t.relop = rel_code;
      end
    endcase
    t.start  = run_start;
    t.length = run_len;
    run_mode = RUN_IDLE;
    return t;
  endfunction

  function automatic void scan_char(logic [7:0] c, logic eol);
    token_t toks[$];
    bit     extend;
    extend = 1'b0;
    case (run_mode)
      RUN_IDENT: extend = is_letter(c) || is_digit(c) || c == "_";
      RUN_NUM:   extend = is_digit(c) || c == "." || c == "e" || c == "E" ||
                          c == "+" || c == "-";
      RUN_REL:   extend = is_rel(c);
      default:   extend = 1'b0;
    endcase

    if (extend) begin
      if (run_mode == RUN_IDENT) begin
        kw_state = kw_advance(kw_state, c);
      end else if (run_mode == RUN_NUM) begin
        num_state = num_advance(num_state, c);
      end else if (run_len == 1) begin
        if (rel_code == REL_LT && c == "=") rel_code = REL_LE;
        else if (rel_code == REL_LT && c == ">") rel_code = REL_NE;
        else if (rel_code == REL_GT && c == "=") rel_code = REL_GE;
      end
      if (run_len != LEN_MAX) run_len++;
    end else begin
      if (run_mode != RUN_IDLE) toks = {toks, close_run()};
      if (is_letter(c) || c == "_") begin
        run_mode = RUN_IDENT;
        if (c == "i") kw_state = KW_I;
        else if (c == "e") kw_state = KW_E;
        else if (c == "t") kw_state = KW_T;
        else kw_state = KW_NONE;
      end else if (is_digit(c)) begin
        run_mode  = RUN_NUM;
        num_state = num_advance(NUM_START, c);
      end else if (is_rel(c)) begin
        run_mode = RUN_REL;
        if (c == "=") rel_code = REL_EQ;
        else if (c == "<") rel_code = REL_LT;
        else rel_code = REL_GT;
      end
      if (run_mode != RUN_IDLE) begin
        run_start = col;
        run_len   = 1;
      end
    end

    if (eol) begin
      if (run_mode != RUN_IDLE) toks = {toks, close_run()};
      col = '0;
    end else if (col < COL_MAX) begin
      col++;
    end

    if (toks.size() == 2) n_two_tok++;
    foreach (toks[i]) begin
      toks[i].last = (i == toks.size() - 1);
      token_q = {token_q, toks[i]};
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] skip_byte();
    logic [7:0] b;
    do b = $urandom_range(0, 255);
    while (is_letter(b) || is_digit(b) || b == "_" || is_rel(b));
    return b;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic add_char(logic [7:0] c, logic eol, bit drain = 1'b0);
    char_item_t it;
    it.ch    = c;
    it.eol   = eol;
    it.drain = drain;
    char_q   = {char_q, it};
    if (eol) n_lines++;
  endtask

  task automatic add_text(string s, bit eol);
    for (int i = 0; i < s.len(); i++) add_char(s[i], eol && i == s.len() - 1);
  endtask

  task automatic put_pick(string set, int n);
    repeat (n) line_buf = {line_buf, set[$urandom_range(0, set.len() - 1)]};
  endtask

  task automatic random_line(bit force_drain);
    string w;
    bit    drain;
    line_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) line_buf = {line_buf, 8'($urandom_range(0, 255))};
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 5))
          0: begin
            w = kw_words[$urandom_range(0, 2)];
            for (int i = 0; i < w.len(); i++) line_buf = {line_buf, w[i]};
          end
          1: begin
            put_pick("abeiltz_Q", 1);
            put_pick("iftheslnxz_09Q", $urandom_range(0, 5));
          end
          2: begin
            put_pick("0123456789", $urandom_range(1, 3));
            if ($urandom_range(0, 1)) begin
              put_pick(".", 1);
              put_pick("0123456789", $urandom_range(1, 2));
            end
            if ($urandom_range(0, 2) == 0) begin
              put_pick("eE", 1);
              if ($urandom_range(0, 1)) put_pick("+-", 1);
              put_pick("0123456789", $urandom_range(1, 2));
            end
          end
          3: begin
            put_pick("0123456789", 1);
            put_pick("0123456789.eE+-", $urandom_range(1, 5));
          end
          default: put_pick("<>=", $urandom_range(1, 3));
        endcase
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 3) != 0) put_pick(" ", 1);
          else line_buf = {line_buf, skip_byte()};
        end
      end
    end
    drain = force_drain || $urandom_range(0, 29) == 0;
    foreach (line_buf[i]) add_char(line_buf[i], i == line_buf.size() - 1, drain && i == 0);
  endtask

  // sender: offer characters from the queue at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || n_accepted == n_offered)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (char_q.size() == 0 || (char_q[0].drain && token_q.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt_char = char_q.pop_front();
        ch_i       <= nxt_char.ch;
        line_end_i <= nxt_char.eol;
        in_valid_i <= 1'b1;
        n_offered++;
        if (src_quiet > 0) begin
          src_quiet--;
          src_gap = 0;
        end else begin
          src_gap = idle_len();
          if ($urandom_range(0, 199) == 0) src_quiet = $urandom_range(50, 200);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to fill the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && n_accepted >= 300) begin
        long_hold_done = 1'b1;
        snk_hold       = 150;
      end
      if (snk_hold > 0) begin
        snk_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (snk_quiet > 0) begin
          snk_quiet--;
        end else begin
          snk_hold = idle_len();
          if ($urandom_range(0, 199) == 0) snk_quiet = $urandom_range(50, 200);
        end
      end
    end
  end

  // predict on input transfer, check on output transfer, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && in_ready_o) begin
        scan_char(ch_i, line_end_i);
        n_accepted++;
        idle_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        got_tok.kind   = token_kind_o;
        got_tok.relop  = relop_kind_o;
        got_tok.start  = start_column_o;
        got_tok.length = token_length_o;
        got_tok.last   = last_of_item_o;
        if (token_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected token, actual kind %0d relop %0d start %0d length %0d last %0d",
                   $time, got_tok.kind, got_tok.relop, got_tok.start, got_tok.length,
                   got_tok.last);
        end else begin
          want_tok = token_q.pop_front();
          check_field("token_kind", want_tok.kind, got_tok.kind);
          check_field("relop_kind", want_tok.relop, got_tok.relop);
          check_field("start_column", want_tok.start, got_tok.start);
          check_field("token_length", want_tok.length, got_tok.length);
          check_field("last_of_item", want_tok.last, got_tok.last);
          kind_seen[want_tok.kind]++;
          n_tokens++;
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d tokens outstanding",
                 $time, idle_cycles, token_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int  rnd_chars;
    bit  long_done;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ch_i        = '0;
    line_end_i  = 1'b0;
    out_ready_i = 1'b0;
    run_mode    = RUN_IDLE;
    kw_state    = KW_NONE;
    num_state   = NUM_START;
    rel_code    = REL_EQ;
    run_start   = '0;
    run_len     = '0;
    col         = '0;
    rnd_chars   = 0;
    long_done   = 1'b0;

    // directed lines
    add_text("if<=else<>then", 1'b1);
    add_text("1.", 1'b0);
    add_char(8'hFF, 1'b0);
    add_text("_>=2", 1'b0);
    add_char(8'h00, 1'b0);
    add_text("=", 1'b1);
    add_text("9>a<", 1'b1);

    random_line(1'b1);
    while (rnd_chars < RAND_CHARS) begin
      random_line(1'b0);
      rnd_chars += line_buf.size();
      if (!long_done && rnd_chars >= RAND_CHARS / 2) begin
        long_done = 1'b1;
        repeat (LONG_RUN) add_char("a", 1'b0);
        add_text(" 12 <= y", 1'b1);
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || n_accepted != n_offered) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (token_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected tokens never arrived", $time, token_q.size());
    end
    $display("Scanned %0d characters on %0d lines, checked %0d tokens, %0d two-token ends.",
             n_accepted, n_lines, n_tokens, n_two_tok);
    $display("Kinds: if %0d else %0d then %0d ident %0d number %0d relop %0d unknown %0d",
             kind_seen[TOK_IF], kind_seen[TOK_ELSE], kind_seen[TOK_THEN],
             kind_seen[TOK_IDENT], kind_seen[TOK_NUMBER], kind_seen[TOK_RELOP],
             kind_seen[TOK_UNKNOWN]);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
